[src/shift_or_match_counter_assert.svh]
// assertion macros used by the shift-or match counter checker
`ifndef SHIFT_OR_MATCH_COUNTER_ASSERT_SVH
`define SHIFT_OR_MATCH_COUNTER_ASSERT_SVH

// implication checked in the next cycle, masked while reset is applied
`define SMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shift_or_match_counter: port check failed");

// condition that must hold in the cycle after reset is seen
`define SMC_ASSERT_AFTER_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("shift_or_match_counter: reset check failed");

`endif

[src/smc_pkg.sv]
// shared types and constants of the shift-or match counter
`default_nettype none

package smc_pkg;

    // field widths of the input, config and result words
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int SYMBOL_W = 8;
    localparam int LEN_W    = 7;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_COUNT_W = 32;

    // selector codes carried in the input tuser
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TEXT,
        OP_RESTART,
        OP_NOP
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [INDEX_W-1:0]    index;
        logic [SYMBOL_W-1:0]   symbol;
    } t_op;

endpackage

`default_nettype wire

[src/shift_or_match_counter.sv]
// top level of the shift-or exact string match counter
//
// shift-or (bitap) matcher that counts occurrences of a pattern of up to
// MAX_PATTERN bytes in a byte stream. every input word gives exactly one
// result word. a word carries a selector in tuser: load a pattern byte at
// an index, feed a text byte, or restart the search (clears state, text
// position and count; pattern and length stay). the pattern length is set
// through the config write port; the user must write it only while the
// block is idle, the block itself does not enforce this. throughput is one
// word per clock in both directions while neither side stalls; a result
// word passes the front register, a queue entry and the result register
// before it is offered. the rate is set by the back stage, which compares
// the text byte against all stored pattern bytes at once and applies the
// shift-or update and count together. the two-entry queue lets input and
// output stall independently. pattern bytes are undefined until loaded,
// there is no clearing pass after reset.
`default_nettype none

module shift_or_match_counter #(
    parameter int MAX_PATTERN = 64,   // pattern store depth, 1..64
    parameter int COUNT_BITS  = 32    // saturating counter width, 8..64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // pattern length register
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [smc_pkg::LEN_W-1:0]         i_cfg_wr_data,   // pattern_length
    // input words
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [smc_pkg::IN_DATA_W-1:0]     s_axis_tdata,    // index[5:0], symbol[13:6]
    input  wire logic [smc_pkg::FUNC_W-1:0]        s_axis_tuser,    // func[1:0]
    // result words
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [smc_pkg::OUT_COUNT_W-1:0]        m_axis_tdata,    // match_count[31:0]
    output logic [0:0]                             m_axis_tuser     // match[0]
);

    // front to queue
    logic         w_front_push;
    smc_pkg::t_op w_front_op;
    logic         w_q_ready;
    // queue to back
    logic         w_q_valid;
    smc_pkg::t_op w_q_op;
    logic         w_q_pop;
    logic         w_match;

    // register the incoming word and decode its selector
    smc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_q_ready  (w_q_ready),
        .o_push     (w_front_push),
        .o_op       (w_front_op)
    );

    // decouples input stalls from output stalls
    smc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_op    (w_front_op),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_op    (w_q_op)
    );

    // pattern store, shift-or state, counter and result register
    smc_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (w_q_valid),
        .i_q_op        (w_q_op),
        .o_q_pop       (w_q_pop),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_match       (w_match),
        .o_count       (m_axis_tdata)
    );

    assign m_axis_tuser = w_match;

endmodule

`default_nettype wire

[src/smc_front.sv]
// front stage: takes input words and classifies them into operations
`default_nettype none

module smc_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [smc_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  wire logic [smc_pkg::FUNC_W-1:0]      i_s_tuser,
    input  wire logic                            i_q_ready,
    output logic                                 o_push,
    output smc_pkg::t_op                         o_op
);

    logic         r_valid;
    smc_pkg::t_op r_op;
    smc_pkg::t_op w_op;

    always_comb begin
        w_op.index  = i_s_tdata[smc_pkg::INDEX_W-1:0];
        w_op.symbol = i_s_tdata[smc_pkg::INDEX_W +: smc_pkg::SYMBOL_W];
        case (i_s_tuser)
            smc_pkg::FUNC_LOAD:    w_op.kind = smc_pkg::OP_LOAD;
            smc_pkg::FUNC_TEXT:    w_op.kind = smc_pkg::OP_TEXT;
            smc_pkg::FUNC_RESTART: w_op.kind = smc_pkg::OP_RESTART;
            default:               w_op.kind = smc_pkg::OP_NOP;
        endcase
    end

    assign o_push     = r_valid && i_q_ready;
    assign o_s_tready = !r_valid || i_q_ready;
    assign o_op       = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op <= w_op;
        end
    end

endmodule

`default_nettype wire

[src/smc_queue.sv]
// two-entry queue between the front and back stages
`default_nettype none

module smc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire smc_pkg::t_op  i_op,
    output logic               o_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output smc_pkg::t_op       o_op
);

    smc_pkg::t_op r_entry [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_entry[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

[src/smc_back.sv]
// back stage: pattern store, shift-or update, match count and result register
`default_nettype none

module smc_back #(
    parameter int MAX_PATTERN = 64,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [smc_pkg::LEN_W-1:0]         i_cfg_wr_data,
    input  wire logic                              i_q_valid,
    input  wire smc_pkg::t_op                      i_q_op,
    output logic                                   o_q_pop,
    input  wire logic                              i_m_tready,
    output logic                                   o_m_tvalid,
    output logic                                   o_match,
    output logic [smc_pkg::OUT_COUNT_W-1:0]        o_count
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW = $clog2(MAX_PATTERN + 1);
    localparam int OB = (COUNT_BITS < smc_pkg::OUT_COUNT_W) ? COUNT_BITS
                                                             : smc_pkg::OUT_COUNT_W;

    logic [smc_pkg::SYMBOL_W-1:0]    r_pattern [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]          r_state;
    logic [PW-1:0]                   r_pos;
    logic [COUNT_BITS-1:0]           r_count;
    logic [smc_pkg::LEN_W-1:0]       r_len;
    logic                            r_out_valid;
    logic                            r_out_match;
    logic [smc_pkg::OUT_COUNT_W-1:0] r_out_count;

    logic                            w_take;
    logic                            w_len_ok;
    logic [MAX_PATTERN-1:0]          w_mask;
    logic [MAX_PATTERN-1:0]          n_state;
    logic [IW-1:0]                   w_bit_idx;
    logic [smc_pkg::LEN_W-1:0]       w_pos_inc;
    logic                            w_hit;
    logic [COUNT_BITS-1:0]           n_count;
    logic [smc_pkg::OUT_COUNT_W-1:0] w_count_out;

    assign w_take  = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_q_pop = w_take;

    assign w_len_ok = (r_len != '0) && (r_len <= smc_pkg::LEN_W'(MAX_PATTERN));

    // one comparator lane per pattern position
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_mask[i] = !(w_len_ok && (smc_pkg::LEN_W'(i) < r_len) &&
                          (r_pattern[i] == i_q_op.symbol));
        end
    end

    assign n_state   = (r_state << 1) | w_mask;
    assign w_bit_idx = IW'(r_len - smc_pkg::LEN_W'(1));
    assign w_pos_inc = smc_pkg::LEN_W'(r_pos) + smc_pkg::LEN_W'(1);
    assign w_hit     = w_len_ok && (w_pos_inc >= r_len) && !n_state[w_bit_idx];
    assign n_count   = (w_hit && (r_count != '1)) ? r_count + COUNT_BITS'(1) : r_count;

    always_comb begin
        w_count_out = '0;
        case (i_q_op.kind)
            smc_pkg::OP_TEXT:    w_count_out[OB-1:0] = n_count[OB-1:0];
            smc_pkg::OP_RESTART: w_count_out = '0;
            default:             w_count_out[OB-1:0] = r_count[OB-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '1;
            r_pos       <= '0;
            r_count     <= '0;
            r_len       <= smc_pkg::LEN_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                case (i_q_op.kind)
                    smc_pkg::OP_TEXT: begin
                        r_state <= n_state;
                        r_count <= n_count;
                        if (r_pos < PW'(MAX_PATTERN)) begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                    smc_pkg::OP_RESTART: begin
                        r_state <= '1;
                        r_pos   <= '0;
                        r_count <= '0;
                    end
                    default: begin
                        r_state <= r_state;
                    end
                endcase
            end
        end
    end

    // pattern bytes and result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_match <= (i_q_op.kind == smc_pkg::OP_TEXT) && w_hit;
            r_out_count <= w_count_out;
            if (i_q_op.kind == smc_pkg::OP_LOAD) begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    if (smc_pkg::INDEX_W'(i) == i_q_op.index) begin
                        r_pattern[i] <= i_q_op.symbol;
                    end
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_match    = r_out_match;
    assign o_count    = r_out_count;

endmodule

`default_nettype wire

[src/smc_checker.sv]
// port-level checks of the shift-or match counter, bound to the top level
`default_nettype none

`include "shift_or_match_counter_assert.svh"

module smc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // a stalled result word stays offered and unchanged
    `SMC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SMC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // no result word is left over from before reset
    `SMC_ASSERT_AFTER_RST(a_rst_out, !m_axis_tvalid)
    // input side is open right after reset
    `SMC_ASSERT_AFTER_RST(a_rst_in, s_axis_tready)

endmodule

bind shift_or_match_counter smc_checker u_smc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[dv/tb_shift_or_match_counter.sv]
// self-checking testbench for the shift-or match counter with a built-in shift-or predictor
`timescale 1ns / 1ps

module tb_shift_or_match_counter;

    localparam int PAT_DEPTH   = 64;
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
    localparam int GAPPED_WORDS = 950;     // word total at which the gapped random part stops
    localparam int FINAL_WORDS  = 1200;    // word total at which the gap-free tail stops
    localparam int MAX_REPORTS  = 50;
    localparam logic [smc_pkg::OUT_COUNT_W-1:0] COUNT_SAT = '1;

    // one expected result word
    typedef struct packed {
        logic                            match;
        logic [smc_pkg::OUT_COUNT_W-1:0] count;
    } t_result;

    // dut ports, every input known from time zero
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [smc_pkg::LEN_W-1:0]       i_cfg_wr_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [smc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;      // index[5:0], symbol[13:6]
    logic [smc_pkg::FUNC_W-1:0]      s_axis_tuser = '0;      // func[1:0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [smc_pkg::OUT_COUNT_W-1:0] m_axis_tdata;           // match_count[31:0]
    logic [0:0]                      m_axis_tuser;           // match[0]

    // predictor state: pattern bytes, shift-or vector, text position, count, length
    logic [smc_pkg::SYMBOL_W-1:0]    pat_bytes [PAT_DEPTH];
    logic [63:0]                     or_state;
    logic [smc_pkg::LEN_W-1:0]       text_pos;
    logic [smc_pkg::OUT_COUNT_W-1:0] occ_count;
    logic [smc_pkg::LEN_W-1:0]       cur_len;
    t_result                         pending_matches [$];

    // stimulus shaping
    int                              src_gap_pct = 20;
    int                              sink_gap_pct = 20;
    int                              sink_hold_req = 0;
    int                              sink_stall_left = 0;
    logic [smc_pkg::SYMBOL_W-1:0]    alphabet [4];
    logic                            wide_text;

    // bookkeeping
    int unsigned                     cycle_count = 0;
    int                              words_sent = 0;
    int                              text_words = 0;
    int                              results_checked = 0;
    int                              matches_seen = 0;
    int                              mismatches = 0;
    logic [127:0]                    lengths_written = '0;
    t_result                         got_want;

    shift_or_match_counter #(
        .MAX_PATTERN(64),
        .COUNT_BITS (32)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_matches.size());
            $display("tb_shift_or_match_counter: FAIL");
            $finish;
        end
    end

    // shift-or update for one accepted word, returns the result word it must produce
    function automatic t_result predict_shift_or(input logic [smc_pkg::FUNC_W-1:0] func,
                                                 input logic [smc_pkg::INDEX_W-1:0] idx,
                                                 input logic [smc_pkg::SYMBOL_W-1:0] sym);
        t_result     res;
        logic [63:0] mask;
        logic        len_ok;
        int          i;
        res.match = 1'b0;
        len_ok = (cur_len >= 1) && (cur_len <= PAT_DEPTH);
        case (func)
            smc_pkg::FUNC_LOAD: begin
                pat_bytes[idx] = sym;
            end
            smc_pkg::FUNC_TEXT: begin
                // bit i clear only where the stored byte equals the text byte
                mask = '1;
                if (len_ok) begin
                    for (i = 0; i < cur_len; i++)
                        if (pat_bytes[i] == sym) mask[i] = 1'b0;
                end
                or_state = (or_state << 1) | mask;
                if (len_ok && text_pos + 1 >= cur_len && !or_state[cur_len - 1]) begin
                    res.match = 1'b1;
                    if (occ_count != COUNT_SAT) occ_count++;
                end
                if (text_pos < PAT_DEPTH) text_pos++;
            end
            smc_pkg::FUNC_RESTART: begin
                or_state  = '1;
                text_pos  = '0;
                occ_count = '0;
            end
            default: begin
                // unused selector leaves everything alone
            end
        endcase
        res.count = occ_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
                     $time, results_checked, what, want, got);
    endtask

    // after an optional idle gap, offer one word, hold it until accepted, then queue its expected result
    task automatic send_word(input logic [smc_pkg::FUNC_W-1:0] func,
                             input logic [smc_pkg::INDEX_W-1:0] idx,
                             input logic [smc_pkg::SYMBOL_W-1:0] sym);
        int gap;
        if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(smc_pkg::IN_DATA_W - smc_pkg::INDEX_W - smc_pkg::SYMBOL_W){1'b0}},
                          sym, idx};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_matches.push_back(predict_shift_or(func, idx, sym));
        words_sent++;
        if (func == smc_pkg::FUNC_TEXT) text_words++;
    endtask

    // stop offering and wait until every expected result word is back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_matches.size() != 0) @(posedge i_clk);
        // three-stage pipe; the extra wait makes sure it is empty
        repeat (4) @(posedge i_clk);
    endtask

    // length register is only written with the block idle
    task automatic write_pattern_length(input logic [smc_pkg::LEN_W-1:0] len);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_len = len;
        lengths_written[len] = 1'b1;
    endtask

    function automatic logic [smc_pkg::SYMBOL_W-1:0] pick_text_byte();
        return wide_text ? smc_pkg::SYMBOL_W'($urandom) : alphabet[$urandom_range(0, 3)];
    endfunction

    // receiver: random stall bursts, plus long hold-offs requested by a test
    always @(posedge i_clk) begin
        if (sink_hold_req > 0) begin
            sink_stall_left = sink_hold_req;
            sink_hold_req = 0;
        end
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_gap_pct > 0 && $urandom_range(0, 99) < sink_gap_pct) begin
            sink_stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker: each accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_matches.size() == 0) begin
                report_mismatch("unexpected result word, count", 64'd0, 64'(m_axis_tdata));
            end else begin
                got_want = pending_matches.pop_front();
                if (m_axis_tuser[0] !== got_want.match)
                    report_mismatch("match", 64'(got_want.match), 64'(m_axis_tuser[0]));
                if (m_axis_tdata !== got_want.count)
                    report_mismatch("match_count", 64'(got_want.count), 64'(m_axis_tdata));
                if (m_axis_tuser[0] === 1'b1) matches_seen++;
            end
            results_checked++;
        end
    end

    // reset length, single-byte hits, restart, unused selector, bad lengths,
    // and a length change that keeps the running state
    task automatic test_directed();
        // nothing is read from the store yet, so these are safe out of reset
        send_word(smc_pkg::FUNC_NONE, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_RESTART, 6'd63, 8'hFF);
        send_word(smc_pkg::FUNC_LOAD, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_LOAD, 6'd63, 8'hFF);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);      // hit at reset length 1
        send_word(smc_pkg::FUNC_TEXT, 6'd63, 8'hFF);     // miss
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);      // hit, count 2
        send_word(smc_pkg::FUNC_NONE, 6'd63, 8'hFF);     // count held
        // zero and oversized lengths never hit but still shift
        write_pattern_length(7'd0);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        write_pattern_length(7'h7F);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        write_pattern_length(7'd65);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        // back to a legal length without a restart
        send_word(smc_pkg::FUNC_LOAD, 6'd1, 8'h00);
        write_pattern_length(7'd2);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_RESTART, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        send_word(smc_pkg::FUNC_TEXT, 6'd0, 8'h00);
        write_pattern_length(7'd1);
        send_word(smc_pkg::FUNC_TEXT, 6'd21, 8'h00);
    endtask

    // full 64-byte pattern: whole copy hits, copy with last byte changed does not
    task automatic test_full_length();
        int i;
        write_pattern_length(7'd64);
        send_word(smc_pkg::FUNC_RESTART, 6'd0, 8'h00);
        for (i = 0; i < PAT_DEPTH; i++)
            send_word(smc_pkg::FUNC_LOAD, smc_pkg::INDEX_W'(i),
                      smc_pkg::SYMBOL_W'($urandom));
        for (i = 0; i < PAT_DEPTH; i++)
            send_word(smc_pkg::FUNC_TEXT, smc_pkg::INDEX_W'($urandom), pat_bytes[i]);
        for (i = 0; i < PAT_DEPTH; i++)
            send_word(smc_pkg::FUNC_TEXT, smc_pkg::INDEX_W'($urandom),
                      (i == PAT_DEPTH - 1) ? pat_bytes[i] ^ 8'h5A : pat_bytes[i]);
    endtask

    // receiver holds off long enough for the block to fill and stall its input,
    // then the sender pauses until every result is back
    task automatic test_backpressure();
        int k;
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        write_pattern_length(7'd3);
        send_word(smc_pkg::FUNC_LOAD, 6'd0, 8'h41);
        send_word(smc_pkg::FUNC_LOAD, 6'd1, 8'h42);
        send_word(smc_pkg::FUNC_LOAD, 6'd2, 8'h41);
        sink_hold_req = 80;
        for (k = 0; k < 30; k++)
            send_word(smc_pkg::FUNC_TEXT, 6'd0,
                      ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h42);
        wait_results_drained();
    endtask

    // random search phases: pick a length, load a pattern, then text that is
    // mostly pattern copies and alphabet bytes with some loads, restarts and nops
    task automatic test_random_search(input int word_target, input logic with_gaps);
        int                        r;
        int                        i;
        int                        span;
        int                        flip;
        int                        phase_end;
        logic [smc_pkg::LEN_W-1:0] len;
        while (words_sent < word_target) begin
            if (with_gaps) begin
                r = $urandom_range(0, 2);
                src_gap_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
                r = $urandom_range(0, 2);
                sink_gap_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
            end else begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end
            r = $urandom_range(0, 19);
            if (r == 0)
                len = ($urandom_range(0, 1) != 0) ? smc_pkg::LEN_W'(0)
                                                  : smc_pkg::LEN_W'($urandom_range(65, 127));
            else if (r == 1)
                len = 7'd64;
            else if (r <= 4)
                len = smc_pkg::LEN_W'($urandom_range(9, 63));
            else
                len = smc_pkg::LEN_W'($urandom_range(1, 8));
            write_pattern_length(len);
            for (i = 0; i < 4; i++) alphabet[i] = smc_pkg::SYMBOL_W'($urandom);
            wide_text = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) != 0)
                send_word(smc_pkg::FUNC_RESTART, smc_pkg::INDEX_W'($urandom),
                          smc_pkg::SYMBOL_W'($urandom));
            // bad lengths still get a short pattern so copies have something to match
            span = (len >= 1 && len <= PAT_DEPTH) ? int'(len) : 8;
            for (i = 0; i < span; i++)
                send_word(smc_pkg::FUNC_LOAD, smc_pkg::INDEX_W'(i), pick_text_byte());
            phase_end = words_sent + ((span > 16) ? 3 * span : $urandom_range(20, 60));
            while (words_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    flip = ($urandom_range(0, 2) == 0) ? $urandom_range(0, span - 1) : -1;
                    for (i = 0; i < span; i++)
                        send_word(smc_pkg::FUNC_TEXT, smc_pkg::INDEX_W'($urandom),
                                  (i == flip) ? pick_text_byte() : pat_bytes[i]);
                end else if (r < 90) begin
                    send_word(smc_pkg::FUNC_TEXT, smc_pkg::INDEX_W'($urandom),
                              pick_text_byte());
                end else if (r < 94) begin
                    // every entry is loaded by now, so any index is fair game
                    send_word(smc_pkg::FUNC_LOAD, smc_pkg::INDEX_W'($urandom),
                              pick_text_byte());
                end else if (r < 97) begin
                    send_word(smc_pkg::FUNC_RESTART, smc_pkg::INDEX_W'($urandom),
                              smc_pkg::SYMBOL_W'($urandom));
                end else begin
                    send_word(smc_pkg::FUNC_NONE, smc_pkg::INDEX_W'($urandom),
                              smc_pkg::SYMBOL_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        or_state  = '1;
        text_pos  = '0;
        occ_count = '0;
        cur_len   = 7'd1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_length();
        test_backpressure();
        test_random_search(GAPPED_WORDS, 1'b1);
        // last stretch streams with no idling on either side
        test_random_search(FINAL_WORDS, 1'b0);

        wait_results_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d words (%0d text bytes), %0d results checked, %0d matches",
                 words_sent, text_words, results_checked, matches_seen);
        $display("%0d distinct pattern lengths incl. 0, 1, 64 and out-of-range, %0d mismatches",
                 $countones(lengths_written), mismatches);
        if (mismatches == 0) begin
            $display("tb_shift_or_match_counter: PASS");
        end else begin
            $display("tb_shift_or_match_counter: FAIL");
        end
        $finish;
    end

endmodule
